FILE: rtl/core/fras_pkg.sv
// Shared types, constants and helper functions for the fraction add/subtract core.
`default_nettype none

package fras_pkg;

   localparam int VALUE_BITS    = 16;
   localparam int WORK_BITS     = 2 * VALUE_BITS;
   localparam int NUM_BITS      = 33;
   localparam int DEN_BITS      = 31;
   localparam int CNT_BITS      = $clog2(WORK_BITS);
   localparam int REQ_DATA_BITS = 4 * VALUE_BITS;
   localparam int RSP_DATA_BITS = 2 * (NUM_BITS + DEN_BITS);

   // Field offsets inside the result tdata
   localparam int SUM_NUM_LSB  = 0;
   localparam int SUM_DEN_LSB  = SUM_NUM_LSB + NUM_BITS;
   localparam int DIFF_NUM_LSB = SUM_DEN_LSB + DEN_BITS;
   localparam int DIFF_DEN_LSB = DIFF_NUM_LSB + NUM_BITS;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [WORK_BITS-1:0]  work_type;
   typedef logic [NUM_BITS-1:0]   num_type;
   typedef logic [DEN_BITS-1:0]   den_type;

   typedef enum logic {
      UNIT_OP_GCD,
      UNIT_OP_DIV
   } fras_op_type;

   typedef struct packed {
      logic        start;
      fras_op_type op;
   } fras_unit_req_type;

   typedef struct packed {
      logic     done;
      work_type result;
   } fras_unit_status_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_GCD,
      UNIT_DIV
   } fras_unit_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD_DEN,
      ST_DIV_D1,
      ST_DIV_D2,
      ST_MUL_LCM,
      ST_MUL_T1,
      ST_MUL_T2,
      ST_COMB_SUM,
      ST_COMB_DIFF,
      ST_GCD_SUM,
      ST_DIV_SUM_NUM,
      ST_DIV_SUM_DEN,
      ST_GCD_DIFF,
      ST_DIV_DIFF_NUM,
      ST_DIV_DIFF_DEN,
      ST_FINISH
   } fras_state_type;

   // Sign-magnitude values: input width and working width
   typedef struct packed {
      logic      neg;
      value_type mag;
   } in_smag_type;

   typedef struct packed {
      logic     neg;
      work_type mag;
   } smag_type;

   function automatic in_smag_type decode(input value_type raw);
      in_smag_type r;
      r.neg = raw[VALUE_BITS-1];
      r.mag = r.neg ? (~raw + 1'b1) : raw;
      return r;
   endfunction

   // Signed add of two sign-magnitude values; zero is always positive
   function automatic smag_type combine(input smag_type p, input smag_type q);
      smag_type r;
      if (p.neg == q.neg) begin
         r.neg = p.neg;
         r.mag = p.mag + q.mag;
      end else if (p.mag >= q.mag) begin
         r.neg = p.neg;
         r.mag = p.mag - q.mag;
      end else begin
         r.neg = q.neg;
         r.mag = q.mag - p.mag;
      end
      if (r.mag == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fraction_add_sub_reduce_core.sv
// Top level of the fraction add/subtract core with reduction to lowest terms.
//
// Takes two signed fractions a/b and c/d (16-bit two's complement each) and
// returns a/b + c/d and a/b - c/d, each reduced to lowest terms, with a
// positive denominator and the sign carried in a 33-bit numerator. A zero
// result comes out as 0/1. A zero input denominator sets rsp_tuser
// (zero_den_error) and gives all-zero result fields. One item is in work at a
// time: req_tready is high only while the sequencer is idle, and a finished
// result waits in the output register so the next item can be taken. The gcd
// runs and divisions use the one shared gcd/divide unit, which does one binary-gcd
// step or one quotient bit per cycle: three gcd runs and six 32-bit divisions.
// The three 16x16 multiplies and the two sign-magnitude combines are done in the
// sequencer. A zero-denominator item skips all arithmetic and goes straight to
// the output.
`default_nettype none

module fraction_add_sub_reduce_core
   import fras_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request: first_num, first_den, second_num, second_den (16 bits each, from bit 0)
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // result: sum_num (33), sum_den (31), diff_num (33), diff_den (31), from bit 0
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // result flag: zero_den_error (1)
   output logic                          rsp_tuser
);

   fras_state_type       state_ff, state_in;
   logic                 issued_ff, issued_in;
   logic                 err_ff, err_in;

   // Decoded operands
   in_smag_type          n1_ff, n1_in, d1_ff, d1_in;
   in_smag_type          n2_ff, n2_in, d2_ff, d2_in;
   in_smag_type          n1_dec, d1_dec, n2_dec, d2_dec;

   // Intermediates
   work_type             g_ff, g_in;
   value_type            q1_ff, q1_in, q2_ff, q2_in;
   work_type             lcm_ff, lcm_in;
   smag_type             t1_ff, t1_in, t2_ff, t2_in;
   smag_type             s_ff, s_in, dd_ff, dd_in;
   work_type             sum_q_ff, sum_q_in, sum_den_ff, sum_den_in;
   work_type             diff_q_ff, diff_q_in, diff_den_ff, diff_den_in;

   // Output register
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   // Shared unit and multiplier
   fras_unit_req_type    unit_req;
   fras_unit_status_type unit_status;
   work_type             unit_opa, unit_opb;
   value_type            mul_a, mul_b;
   work_type             mul_prod;
   smag_type             cmb_q, cmb_r;

   num_type              sum_num_out, diff_num_out;
   logic                 req_accept;
   logic                 out_free;

   assign n1_dec = decode(req_tdata[0*VALUE_BITS +: VALUE_BITS]);
   assign d1_dec = decode(req_tdata[1*VALUE_BITS +: VALUE_BITS]);
   assign n2_dec = decode(req_tdata[2*VALUE_BITS +: VALUE_BITS]);
   assign d2_dec = decode(req_tdata[3*VALUE_BITS +: VALUE_BITS]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   assign mul_prod = mul_a * mul_b;
   assign cmb_r    = combine(t1_ff, cmb_q);

   // Apply the sign to the reduced magnitudes
   assign sum_num_out  = s_ff.neg  ? (~{1'b0, sum_q_ff} + 1'b1)  : {1'b0, sum_q_ff};
   assign diff_num_out = dd_ff.neg ? (~{1'b0, diff_q_ff} + 1'b1) : {1'b0, diff_q_ff};

   fras_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (unit_req),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .status (unit_status)
   );

   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      err_in         = err_ff;
      n1_in          = n1_ff;
      d1_in          = d1_ff;
      n2_in          = n2_ff;
      d2_in          = d2_ff;
      g_in           = g_ff;
      q1_in          = q1_ff;
      q2_in          = q2_ff;
      lcm_in         = lcm_ff;
      t1_in          = t1_ff;
      t2_in          = t2_ff;
      s_in           = s_ff;
      dd_in          = dd_ff;
      sum_q_in       = sum_q_ff;
      sum_den_in     = sum_den_ff;
      diff_q_in      = diff_q_ff;
      diff_den_in    = diff_den_ff;
      rsp_tvalid_in  = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      unit_req.start = 1'b0;
      unit_req.op    = UNIT_OP_GCD;
      unit_opa       = '0;
      unit_opb       = '0;
      mul_a          = '0;
      mul_b          = '0;
      cmb_q          = t2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            issued_in = 1'b0;
            if (req_accept) begin
               n1_in  = n1_dec;
               d1_in  = d1_dec;
               n2_in  = n2_dec;
               d2_in  = d2_dec;
               err_in = (d1_dec.mag == '0) || (d2_dec.mag == '0);
               // a zero denominator skips all arithmetic
               state_in = err_in ? ST_FINISH : ST_GCD_DEN;
            end
         end
         ST_GCD_DEN: begin
            unit_req.op    = UNIT_OP_GCD;
            unit_opa       = WORK_BITS'(d1_ff.mag);
            unit_opb       = WORK_BITS'(d2_ff.mag);
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               g_in      = unit_status.result;
               issued_in = 1'b0;
               state_in  = ST_DIV_D1;
            end
         end
         ST_DIV_D1: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = WORK_BITS'(d1_ff.mag);
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               q1_in     = unit_status.result[VALUE_BITS-1:0];
               issued_in = 1'b0;
               state_in  = ST_DIV_D2;
            end
         end
         ST_DIV_D2: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = WORK_BITS'(d2_ff.mag);
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               q2_in     = unit_status.result[VALUE_BITS-1:0];
               issued_in = 1'b0;
               state_in  = ST_MUL_LCM;
            end
         end
         ST_MUL_LCM: begin
            // lcm = (|b| / g) * |d|
            mul_a    = q1_ff;
            mul_b    = d2_ff.mag;
            lcm_in   = mul_prod;
            state_in = ST_MUL_T1;
         end
         ST_MUL_T1: begin
            // scale a by lcm / |b| = |d| / g
            mul_a     = n1_ff.mag;
            mul_b     = q2_ff;
            t1_in.mag = mul_prod;
            t1_in.neg = n1_ff.neg ^ d1_ff.neg;
            state_in  = ST_MUL_T2;
         end
         ST_MUL_T2: begin
            mul_a     = n2_ff.mag;
            mul_b     = q1_ff;
            t2_in.mag = mul_prod;
            t2_in.neg = n2_ff.neg ^ d2_ff.neg;
            state_in  = ST_COMB_SUM;
         end
         ST_COMB_SUM: begin
            cmb_q    = t2_ff;
            s_in     = cmb_r;
            state_in = ST_COMB_DIFF;
         end
         ST_COMB_DIFF: begin
            // flip the sign of the second term for the difference
            cmb_q.neg = ~t2_ff.neg;
            cmb_q.mag = t2_ff.mag;
            dd_in     = cmb_r;
            state_in  = ST_GCD_SUM;
         end
         ST_GCD_SUM: begin
            unit_req.op    = UNIT_OP_GCD;
            unit_opa       = lcm_ff;
            unit_opb       = s_ff.mag;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               g_in      = unit_status.result;
               issued_in = 1'b0;
               state_in  = ST_DIV_SUM_NUM;
            end
         end
         ST_DIV_SUM_NUM: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = s_ff.mag;
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               sum_q_in  = unit_status.result;
               issued_in = 1'b0;
               state_in  = ST_DIV_SUM_DEN;
            end
         end
         ST_DIV_SUM_DEN: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = lcm_ff;
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               sum_den_in = unit_status.result;
               issued_in  = 1'b0;
               state_in   = ST_GCD_DIFF;
            end
         end
         ST_GCD_DIFF: begin
            unit_req.op    = UNIT_OP_GCD;
            unit_opa       = lcm_ff;
            unit_opb       = dd_ff.mag;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               g_in      = unit_status.result;
               issued_in = 1'b0;
               state_in  = ST_DIV_DIFF_NUM;
            end
         end
         ST_DIV_DIFF_NUM: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = dd_ff.mag;
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               diff_q_in = unit_status.result;
               issued_in = 1'b0;
               state_in  = ST_DIV_DIFF_DEN;
            end
         end
         ST_DIV_DIFF_DEN: begin
            unit_req.op    = UNIT_OP_DIV;
            unit_opa       = lcm_ff;
            unit_opb       = g_ff;
            unit_req.start = ~issued_ff;
            issued_in      = 1'b1;
            if (unit_status.done) begin
               diff_den_in = unit_status.result;
               issued_in   = 1'b0;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free, then load it
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = err_ff;
               if (err_ff) begin
                  rsp_tdata_in = '0;
               end else begin
                  rsp_tdata_in = {diff_den_ff[DEN_BITS-1:0], diff_num_out,
                                  sum_den_ff[DEN_BITS-1:0], sum_num_out};
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issued_ff     <= issued_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      err_ff       <= err_in;
      n1_ff        <= n1_in;
      d1_ff        <= d1_in;
      n2_ff        <= n2_in;
      d2_ff        <= d2_in;
      g_ff         <= g_in;
      q1_ff        <= q1_in;
      q2_ff        <= q2_in;
      lcm_ff       <= lcm_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      s_ff         <= s_in;
      dd_ff        <= dd_in;
      sum_q_ff     <= sum_q_in;
      sum_den_ff   <= sum_den_in;
      diff_q_ff    <= diff_q_in;
      diff_den_ff  <= diff_den_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fras_unit.sv
// Shared multi-cycle unit: binary gcd or restoring divide, one step per cycle.
`default_nettype none

module fras_unit
   import fras_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fras_unit_req_type    req,
   input  wire work_type             opa,
   input  wire work_type             opb,
   output fras_unit_status_type      status
);

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORK_BITS - 1);

   fras_unit_state_type state_ff, state_in;
   work_type            u_ff, u_in;
   work_type            v_ff, v_in;
   work_type            r_ff, r_in;
   work_type            result_ff, result_in;
   logic [CNT_BITS-1:0] k_ff, k_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [WORK_BITS:0]   rem_shift;
   logic [WORK_BITS+1:0] rem_diff;
   logic                 rem_ge;
   logic [WORK_BITS:0]   uv_diff;
   work_type             vu_diff;
   logic                 u_ge_v;
   work_type             quo_next;

   // Divide step: shift in the next dividend bit, subtract when it fits
   assign rem_shift = {r_ff, u_ff[WORK_BITS-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, v_ff};
   assign rem_ge    = ~rem_diff[WORK_BITS+1];
   assign quo_next  = {u_ff[WORK_BITS-2:0], rem_ge};

   // Gcd step: odd-odd reduction
   assign uv_diff = {1'b0, u_ff} - {1'b0, v_ff};
   assign u_ge_v  = ~uv_diff[WORK_BITS];
   assign vu_diff = v_ff - u_ff;

   always_comb begin
      state_in  = state_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      r_in      = r_ff;
      result_in = result_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         UNIT_IDLE: begin
            if (req.start) begin
               u_in     = opa;
               v_in     = opb;
               r_in     = '0;
               k_in     = '0;
               cnt_in   = '0;
               state_in = (req.op == UNIT_OP_GCD) ? UNIT_GCD : UNIT_DIV;
            end
         end
         UNIT_GCD: begin
            priority if (u_ff == '0 || v_ff == '0) begin
               result_in = (u_ff | v_ff) << k_ff;
               done_in   = 1'b1;
               state_in  = UNIT_IDLE;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ge_v) begin
               u_in = uv_diff[WORK_BITS-1:0] >> 1;
            end else begin
               v_in = vu_diff >> 1;
            end
         end
         UNIT_DIV: begin
            r_in   = rem_ge ? rem_diff[WORK_BITS-1:0] : rem_shift[WORK_BITS-1:0];
            u_in   = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               result_in = quo_next;
               done_in   = 1'b1;
               state_in  = UNIT_IDLE;
            end
         end
         default: begin
            state_in = UNIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      u_ff      <= u_in;
      v_ff      <= v_in;
      r_ff      <= r_in;
      result_ff <= result_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
   end

   assign status.done   = done_ff;
   assign status.result = result_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fras_check.sv
// Port-level checker for the fraction add/subtract core, bound to the top level.
`default_nettype none

module fras_check
   import fras_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                     rsp_tuser
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // One item at a time: no new item right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // Zero denominator gives all-zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error item carries nonzero fields");

   // Valid results have nonzero denominators
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[SUM_DEN_LSB +: DEN_BITS] != '0 &&
         rsp_tdata[DIFF_DEN_LSB +: DEN_BITS] != '0)
      else $error("zero denominator in a valid result");

   // A zero sum is reported as 0/1
   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[SUM_NUM_LSB +: NUM_BITS] == '0 |->
         rsp_tdata[SUM_DEN_LSB +: DEN_BITS] == DEN_BITS'(1))
      else $error("zero sum not reduced to 0/1");

endmodule

bind fraction_add_sub_reduce_core fras_check u_fras_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: sim/fraction_add_sub_reduce_checker.sv
`timescale 1ns / 100ps
// Checker for the fraction add/subtract core: predicts reduced sum and difference, compares results.
module fraction_add_sub_reduce_checker
   import fras_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     rsp_tuser,
   output int                            mismatch_count,
   output int                            awaited_count
);

   typedef struct packed {
      logic    zero_den;
      den_type diff_den;
      num_type diff_num;
      den_type sum_den;
      num_type sum_num;
   } rational_pair_type;

   typedef struct {
      logic            neg;
      longint unsigned mag;
   } signed_mag_type;

   rational_pair_type awaited_results[$];
   int                mismatches   = 0;
   int                awaited_now  = 0;
   int                result_index = 0;

   assign mismatch_count = mismatches;
   assign awaited_count  = awaited_now;

   function automatic signed_mag_type split_value(input value_type raw);
      signed_mag_type r;
      r.neg = raw[VALUE_BITS-1];
      r.mag = r.neg ? (longint'(1) << VALUE_BITS) - longint'(raw) : longint'(raw);
      return r;
   endfunction

   function automatic longint unsigned euclid_gcd(input longint unsigned a,
                                                  input longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic signed_mag_type add_signed(input signed_mag_type p,
                                                 input signed_mag_type q);
      signed_mag_type r;
      if (p.neg == q.neg) begin
         r.neg = p.neg;
         r.mag = p.mag + q.mag;
      end else if (p.mag >= q.mag) begin
         r.neg = p.neg;
         r.mag = p.mag - q.mag;
      end else begin
         r.neg = q.neg;
         r.mag = q.mag - p.mag;
      end
      if (r.mag == 0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   // Divide numerator and denominator by their gcd, wrap into the result fields
   function automatic void lowest_terms(input signed_mag_type v, input longint unsigned den,
                                        output num_type num_out, output den_type den_out);
      longint unsigned g;
      longint unsigned n;
      logic [63:0]     wide_num;
      logic [63:0]     wide_den;
      g        = euclid_gcd(den, v.mag);
      n        = v.mag / g;
      wide_num = v.neg ? (64'd0 - n) : n;
      wide_den = den / g;
      num_out  = wide_num[NUM_BITS-1:0];
      den_out  = wide_den[DEN_BITS-1:0];
   endfunction

   function automatic rational_pair_type add_sub_reduced(input logic [REQ_DATA_BITS-1:0] data);
      signed_mag_type    n1, d1, n2, d2, t1, t2, total, gap;
      longint unsigned   common_den;
      rational_pair_type r;
      n1 = split_value(data[0*VALUE_BITS +: VALUE_BITS]);
      d1 = split_value(data[1*VALUE_BITS +: VALUE_BITS]);
      n2 = split_value(data[2*VALUE_BITS +: VALUE_BITS]);
      d2 = split_value(data[3*VALUE_BITS +: VALUE_BITS]);
      r  = '0;
      if (d1.mag == 0 || d2.mag == 0) begin
         r.zero_den = 1'b1;
         return r;
      end
      common_den = (d1.mag / euclid_gcd(d1.mag, d2.mag)) * d2.mag;
      t1.neg = n1.neg ^ d1.neg;
      t1.mag = n1.mag * (common_den / d1.mag);
      t2.neg = n2.neg ^ d2.neg;
      t2.mag = n2.mag * (common_den / d2.mag);
      total  = add_signed(t1, t2);
      t2.neg = ~t2.neg;
      gap    = add_signed(t1, t2);
      lowest_terms(total, common_den, r.sum_num, r.sum_den);
      lowest_terms(gap, common_den, r.diff_num, r.diff_den);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] seen,
                                input logic [63:0] wanted);
      mismatches++;
      $display("result %0d: %s got %h, expected %h", result_index, what, seen, wanted);
   endtask

   always @(posedge clock) begin : watch
      rational_pair_type got;
      rational_pair_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.sum_num  = rsp_tdata[SUM_NUM_LSB +: NUM_BITS];
            got.sum_den  = rsp_tdata[SUM_DEN_LSB +: DEN_BITS];
            got.diff_num = rsp_tdata[DIFF_NUM_LSB +: NUM_BITS];
            got.diff_den = rsp_tdata[DIFF_DEN_LSB +: DEN_BITS];
            got.zero_den = rsp_tuser;
            if (awaited_results.size() == 0) begin
               note_mismatch("unexpected result", 64'(got.sum_num), 64'd0);
            end else begin
               want = awaited_results.pop_front();
               if (got.sum_num !== want.sum_num)
                  note_mismatch("sum_num", 64'(got.sum_num), 64'(want.sum_num));
               if (got.sum_den !== want.sum_den)
                  note_mismatch("sum_den", 64'(got.sum_den), 64'(want.sum_den));
               if (got.diff_num !== want.diff_num)
                  note_mismatch("diff_num", 64'(got.diff_num), 64'(want.diff_num));
               if (got.diff_den !== want.diff_den)
                  note_mismatch("diff_den", 64'(got.diff_den), 64'(want.diff_den));
               if (got.zero_den !== want.zero_den)
                  note_mismatch("zero_den_error", 64'(got.zero_den), 64'(want.zero_den));
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(add_sub_reduced(req_tdata));
         end
      end
      awaited_now <= awaited_results.size();
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Top of the fraction add/subtract testbench: clock, reset, stimulus and verdict.
module tb;
   import fras_pkg::*;

   localparam int RANDOM_ITEMS  = 1400;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 20;
   localparam int STEADY_FIRST  = 500;
   localparam int STEADY_LAST   = 700;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // first_num, first_den, second_num, second_den
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // sum_num, sum_den, diff_num, diff_den
   logic                     rsp_tuser;         // zero_den_error

   // High during a stretch of the random part: no idling on either side
   logic steady = 1'b0;

   int cycle_count = 0;
   int mismatch_count;
   int awaited_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fraction_add_sub_reduce_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fraction_add_sub_reduce_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // Stall the result side about one cycle in four, except in the steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 25);
   end

   // Abort a hung run; the limit covers the slowest legal run several times over
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Field value biased toward extremes and small magnitudes
   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) begin
         case ($urandom_range(5))
            0:       return value_type'(16'h8000);
            1:       return value_type'(16'h8001);
            2:       return value_type'(16'hffff);
            3:       return value_type'(16'h0000);
            4:       return value_type'(16'h0001);
            default: return value_type'(16'h7fff);
         endcase
      end else if (sel < 30) begin
         return value_type'(int'($urandom_range(32)) - 16);
      end
      return value_type'($urandom);
   endfunction

   // Denominator: zero only now and then
   function automatic value_type pick_den();
      value_type v;
      if ($urandom_range(99) < 3) begin
         return '0;
      end
      do begin
         v = pick_value();
      end while (v == '0);
      return v;
   endfunction

   // Present one item at a falling edge and hold it until it is taken.
   // Entered and left at a falling edge.
   task automatic send_fraction_pair(input int first_num, input int first_den,
                                     input int second_num, input int second_den);
      // Drop valid for a long gap now and then, so items also land on an idle block
      if (!steady && $urandom_range(99) < 4) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(500, 1)) @(negedge clock);
      end
      // Idle about one cycle in four
      while (!steady && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {value_type'(second_den), value_type'(second_num),
                     value_type'(first_den), value_type'(first_num)};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin : stimulus
      value_type a, b, c, e;
      int        k;
      int        sel;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: simple case, zero denominators, zero results, extremes, signs
      send_fraction_pair(1, 2, 1, 3);
      send_fraction_pair(0, 0, 1, 3);
      send_fraction_pair(1, 3, 5, 0);
      send_fraction_pair(7, 0, -7, 0);
      send_fraction_pair(1, 2, -1, 2);
      send_fraction_pair(3, 4, 3, 4);
      send_fraction_pair(0, 5, 0, -7);
      send_fraction_pair(0, -3, 0, 3);
      send_fraction_pair(-32768, 32767, 32767, -32768);
      send_fraction_pair(-32768, -32768, -32768, -32768);
      send_fraction_pair(-32768, 1, -32768, 1);
      send_fraction_pair(32767, 1, 32767, 1);
      send_fraction_pair(1, 32767, 1, -32768);
      send_fraction_pair(-32768, 0, 32767, -32768);
      send_fraction_pair(3, -4, -5, 6);
      send_fraction_pair(6, 8, 9, 12);
      send_fraction_pair(-1, -1, 1, 1);
      send_fraction_pair(5, 7, 2, 7);
      send_fraction_pair(32767, -32767, 0, 1);
      send_fraction_pair(-12, 18, 30, -45);

      // Random: related pairs for zero results, shared denominators, and free values
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
         sel    = $urandom_range(99);
         if (sel < 15) begin
            // Second is a scaled copy of the first, possibly negated
            k = $urandom_range(4, 1);
            a = value_type'(int'($urandom_range(16000)) - 8000);
            do begin
               b = value_type'(int'($urandom_range(16000)) - 8000);
            end while (b == '0);
            c = value_type'(($urandom_range(1) ? k : -k) * int'($signed(a)));
            e = value_type'(k * int'($signed(b)));
         end else if (sel < 30) begin
            a = pick_value();
            b = pick_den();
            c = pick_value();
            e = b;
         end else begin
            a = pick_value();
            b = pick_den();
            c = pick_value();
            e = pick_den();
         end
         send_fraction_pair(int'($signed(a)), int'($signed(b)),
                            int'($signed(c)), int'($signed(e)));
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then let the block settle
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
